### hdl/strs_pkg.sv
// Shared types and constants for the segment tree range sum block.
package strs_pkg;

  localparam int IDX_W   = 10;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;

  // Request word: operation, positions and delta
  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          index_lo;
    logic [IDX_W-1:0]          index_hi;
    logic signed [DELTA_W-1:0] delta;
  } req_t;

  // Response word: range sum and error flag
  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } rsp_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_LOAD     = 3'd2,
    OP_ADD_LEAF = 3'd3,
    OP_ADD_UP   = 3'd4,
    OP_Q_LEFT   = 3'd5,
    OP_Q_RIGHT  = 3'd6
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic add_ok;
    logic query_ok;
    logic add_top;
    logic walk_done;
  } dp_sts_t;

endpackage

### hdl/strs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module strs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/strs_dp.sv
// Datapath: tree store, node pointers, accumulator and response register.
module strs_dp #(
  parameter int LEAVES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  strs_pkg::req_t   req,
  input  strs_pkg::dp_cmd_t cmd,
  output strs_pkg::dp_sts_t sts,
  output strs_pkg::rsp_t   rsp
);
  import strs_pkg::*;

  localparam int AW    = $clog2(LEAVES) + 1;
  localparam int DEPTH = 2 * LEAVES;
  localparam int XW    = (AW > IDX_W + 1) ? AW : IDX_W + 1;
  localparam logic [XW-1:0] LIM    = XW'(LEAVES - 2);
  localparam logic [XW-1:0] LEAF_X = XW'(LEAVES);

  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic [AW-1:0]    left, left_next;
  logic [AW-1:0]    right, right_next;
  logic [SUM_W-1:0] acc, acc_next;
  logic [DELTA_W-1:0] delta_q;
  logic             err_q;
  logic             rd_pend, rd_pend_next;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [SUM_W-1:0] wdata, rdata, sum_up;
  logic [XW-1:0]    lo_x, hi_x;

  strs_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Input checks
  assign lo_x = XW'(req.index_lo);
  assign hi_x = XW'(req.index_hi);

  always_comb begin
    sts.clear_last = &clr_addr;
    sts.is_query   = req.operation;
    sts.add_ok     = (lo_x != '0) && (lo_x <= LIM);
    sts.query_ok   = (lo_x != '0) && (hi_x <= LIM) && (lo_x <= hi_x);
    sts.add_top    = (left == AW'(1));
    sts.walk_done  = ((left ^ right) == AW'(1)) || (left == '0);
  end

  // Leaf gets its old value plus the sign-extended delta, ancestors get the running sum plus sibling
  assign sum_up = (cmd.op == OP_ADD_LEAF)
                ? rdata + {{(SUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q}
                : acc + rdata;

  // Command decode
  always_comb begin
    we            = 1'b0;
    waddr         = left;
    wdata         = sum_up;
    raddr         = left ^ AW'(1);
    clr_addr_next = clr_addr;
    left_next     = left;
    right_next    = right;
    rd_pend_next  = 1'b0;
    acc_next      = rd_pend ? acc + rdata : acc;
    case (cmd.op)
      OP_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        wdata         = '0;
        clr_addr_next = clr_addr + AW'(1);
      end
      OP_LOAD: begin
        acc_next = '0;
        if (req.operation) begin
          left_next  = AW'(lo_x + LEAF_X - XW'(1));
          right_next = AW'(hi_x + LEAF_X + XW'(1));
        end else begin
          left_next = AW'(lo_x + LEAF_X);
        end
        raddr = AW'(lo_x + LEAF_X);
      end
      OP_ADD_LEAF, OP_ADD_UP: begin
        we        = 1'b1;
        acc_next  = sum_up;
        left_next = left >> 1;
      end
      OP_Q_LEFT: begin
        rd_pend_next = !left[0] && !sts.walk_done;
      end
      OP_Q_RIGHT: begin
        raddr        = right ^ AW'(1);
        rd_pend_next = right[0];
        left_next    = left >> 1;
        right_next   = right >> 1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      clr_addr <= clr_addr_next;
      rd_pend  <= rd_pend_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left  <= left_next;
    right <= right_next;
    acc   <= acc_next;
    if (cmd.op == OP_LOAD) begin
      delta_q <= req.delta;
      err_q   <= !sts.query_ok;
    end
    if (cmd.out_load) begin
      rsp.range_sum   <= acc;
      rsp.range_error <= err_q;
    end
  end

  // A pending read only follows a query walk step
  a_pend_from_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(cmd.op == OP_Q_LEFT || cmd.op == OP_Q_RIGHT))
    else $error("read pending without a walk step");

endmodule

### hdl/strs_ctrl.sv
// Controller: clearing pass, add climb, query walk and response handoff.
module strs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  strs_pkg::dp_sts_t  sts,
  output strs_pkg::dp_cmd_t  cmd
);
  import strs_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_ADD_LEAF = 7'b0000100,
    S_ADD_UP   = 7'b0001000,
    S_Q_LEFT   = 7'b0010000,
    S_Q_RIGHT  = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_full, out_full_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_full;

  // Next state and datapath command
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = OP_LOAD;
          if (!sts.is_query) begin
            if (sts.add_ok) state_next = S_ADD_LEAF;
          end else if (sts.query_ok) begin
            state_next = S_Q_LEFT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_ADD_LEAF: begin
        cmd.op     = OP_ADD_LEAF;
        state_next = S_ADD_UP;
      end
      S_ADD_UP: begin
        cmd.op = OP_ADD_UP;
        if (sts.add_top) state_next = S_IDLE;
      end
      S_Q_LEFT: begin
        cmd.op     = OP_Q_LEFT;
        state_next = sts.walk_done ? S_FINISH : S_Q_RIGHT;
      end
      S_Q_RIGHT: begin
        cmd.op     = OP_Q_RIGHT;
        state_next = S_Q_LEFT;
      end
      S_FINISH: begin
        if (!out_full || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Response register occupancy
  always_comb begin
    out_full_next = out_full;
    if (cmd.out_load) out_full_next = 1'b1;
    else if (rsp_ready) out_full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state == S_FINISH))
    else $error("response loaded outside finish");

  a_climb_continues: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD_UP) && !sts.add_top |=> (state == S_ADD_UP))
    else $error("add climb stopped below the root");

  a_bad_add_dropped: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !sts.is_query && !sts.add_ok |=> (state == S_IDLE))
    else $error("bad add started work");

endmodule

### hdl/segment_tree_range_sum_top.sv
// Top level of the segment tree point-add / range-sum block.
//
//   channel  dir  handshake              word
//   req      in   req_valid/req_ready    strs_pkg::req_t
//   rsp      out  rsp_valid/rsp_ready    strs_pkg::rsp_t (queries only)
//
// Add: one tree level per cycle, with one RAM read and one write each.
// Query: a left step and a right step per tree level climbed; the single
// RAM read port takes one sibling per cycle. Bad queries go straight to
// the finish step; bad adds are dropped and the block stays idle.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per
// cycle; req_ready stays low until the pass ends.
// A finished query waits in the response register; the next query holds in
// its last step until the previous response is taken.
module segment_tree_range_sum_top #(
  parameter int LEAVES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  strs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output strs_pkg::rsp_t rsp
);
  import strs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  strs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  strs_dp #(.LEAVES(LEAVES)) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

### test/strs_tb_pkg.sv
// Testbench constants for the segment tree range sum block.
package strs_tb_pkg;

  // Leaf count the block is built with in this bench
  localparam int TREE_LEAVES = 1024;

  // Request operation codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

### test/range_sum_checker.sv
// Tree mirror and response checker for the segment tree range sum block.
module range_sum_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  strs_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  strs_pkg::rsp_t rsp,
  output int             mismatches,
  output int             sums_due_count,
  output int             queries_seen,
  output int             bad_queries,
  output int             adds_applied,
  output int             adds_dropped
);
  import strs_pkg::*;
  import strs_tb_pkg::*;

  // Mirror of the tree: leaf p at TREE_LEAVES + p, node 0 unused
  logic [SUM_W-1:0] node_sum [0:2*TREE_LEAVES-1];
  // Range sums still owed by the block, oldest first
  rsp_t sums_due [$];

  function automatic logic position_valid(int unsigned p);
    return p >= 1 && p <= TREE_LEAVES - 2;
  endfunction

  // Point add, then rebuild every ancestor from its two children
  function automatic void apply_add(int unsigned p, logic [SUM_W-1:0] d);
    int unsigned node;
    node = p + TREE_LEAVES;
    node_sum[node] = node_sum[node] + d;
    for (node = node >> 1; node != 0; node = node >> 1)
      node_sum[node] = node_sum[2*node] + node_sum[2*node + 1];
  endfunction

  // Open-interval walk: bounds start one leaf outside and climb to siblings
  function automatic logic [SUM_W-1:0] walk_range_sum(int unsigned lo, int unsigned hi);
    logic [SUM_W-1:0] acc;
    int unsigned      left_node;
    int unsigned      right_node;
    acc = '0;
    left_node = lo + TREE_LEAVES - 1;
    right_node = hi + TREE_LEAVES + 1;
    while ((left_node ^ right_node) != 1 && left_node != 0) begin
      if (left_node[0] == 1'b0)
        acc = acc + node_sum[left_node ^ 1];
      if (right_node[0] == 1'b1)
        acc = acc + node_sum[right_node ^ 1];
      left_node = left_node >> 1;
      right_node = right_node >> 1;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    rsp_t             due;
    logic [SUM_W-1:0] d_ext;
    if (rst) begin
      for (int n = 0; n < 2*TREE_LEAVES; n++)
        node_sum[n] = '0;
      sums_due.delete();
      mismatches = 0;
      queries_seen = 0;
      bad_queries = 0;
      adds_applied = 0;
      adds_dropped = 0;
    end else begin
      // Compare a returned word with the oldest owed sum
      if (rsp_valid && rsp_ready) begin
        if (sums_due.size() == 0) begin
          $error("response word with no query waiting: range_sum %0d, range_error %0b",
                 rsp.range_sum, rsp.range_error);
          mismatches++;
        end else begin
          due = sums_due.pop_front();
          if (rsp.range_sum !== due.range_sum) begin
            $error("range_sum: expected %0d, got %0d", due.range_sum, rsp.range_sum);
            mismatches++;
          end
          if (rsp.range_error !== due.range_error) begin
            $error("range_error: expected %0b, got %0b", due.range_error, rsp.range_error);
            mismatches++;
          end
        end
      end

      // Update the mirror for an accepted request word
      if (req_valid && req_ready) begin
        if (req.operation == REQ_ADD) begin
          if (position_valid(32'(req.index_lo))) begin
            d_ext = {{(SUM_W-DELTA_W){req.delta[DELTA_W-1]}}, req.delta};
            apply_add(32'(req.index_lo), d_ext);
            adds_applied++;
          end else begin
            adds_dropped++;
          end
        end else begin
          queries_seen++;
          if (!position_valid(32'(req.index_lo)) || !position_valid(32'(req.index_hi)) ||
              req.index_lo > req.index_hi) begin
            due.range_sum = '0;
            due.range_error = 1'b1;
            bad_queries++;
          end else begin
            due.range_sum = walk_range_sum(32'(req.index_lo), 32'(req.index_hi));
            due.range_error = 1'b0;
          end
          sums_due = {sums_due, due};
        end
      end
    end
    sums_due_count = sums_due.size();
  end

endmodule

### test/segment_tree_range_sum_top_tb.sv
// Testbench top: stimulus, flow control and verdict for the range sum block.
module segment_tree_range_sum_top_tb;
  import strs_pkg::*;
  import strs_tb_pkg::*;

  localparam int RUN_ITEMS    = 1200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TOP_POS      = TREE_LEAVES - 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int          mismatches;
  int          sums_due_count;
  int          queries_seen;
  int          bad_queries;
  int          adds_applied;
  int          adds_dropped;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          ready_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  segment_tree_range_sum_top #(.LEAVES(TREE_LEAVES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  range_sum_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatches     (mismatches),
    .sums_due_count (sums_due_count),
    .queries_seen   (queries_seen),
    .bad_queries    (bad_queries),
    .adds_applied   (adds_applied),
    .adds_dropped   (adds_dropped)
  );

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL segment_tree_range_sum_top");
      $finish;
    end
  end

  // Receiver: long ready stretches broken by short stalls
  always @(negedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 9) < 6) begin
      rsp_ready <= 1'b1;
      ready_left <= $urandom_range(0, 30);
    end else begin
      rsp_ready <= 1'b0;
      ready_left <= $urandom_range(0, 5);
    end
  end

  function automatic req_t make_word(logic op, int unsigned lo, int unsigned hi,
                                     logic [DELTA_W-1:0] d);
    req_t w;
    w.operation = op;
    w.index_lo = lo[IDX_W-1:0];
    w.index_hi = hi[IDX_W-1:0];
    w.delta = d;
    return w;
  endfunction

  // Present one word; bursts keep valid high, gaps drop it
  task automatic send_word(input req_t w);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
  endtask

  // Stop sending until every owed sum has come back
  task automatic hold_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (sums_due_count == 0);
    burst_left = 0;
  endtask

  initial begin
    int          pick;
    int unsigned lo;
    int unsigned hi;
    logic [DELTA_W-1:0] d;
    logic        op;
    int          live_items;
    bit          mid_pause_done;
    live_items = 0;
    mid_pause_done = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tree, field extremes, ignored adds, invalid ranges
    send_word(make_word(REQ_QUERY, 1, TOP_POS, 32'h0));
    send_word(make_word(REQ_ADD, 1, 0, 32'h7FFF_FFFF));
    send_word(make_word(REQ_ADD, TOP_POS, 1023, 32'h8000_0000));
    send_word(make_word(REQ_ADD, 0, 5, 32'h0000_0005));
    send_word(make_word(REQ_ADD, 1023, 1023, 32'hFFFF_FFFF));
    send_word(make_word(REQ_ADD, 512, 0, 32'hFFFF_FFFF));
    send_word(make_word(REQ_ADD, 511, 1023, 32'h5555_AAAA));
    send_word(make_word(REQ_QUERY, 1, TOP_POS, 32'hFFFF_FFFF));
    send_word(make_word(REQ_QUERY, 1, 1, 32'h0));
    send_word(make_word(REQ_QUERY, TOP_POS, TOP_POS, 32'h0));
    send_word(make_word(REQ_QUERY, 511, 513, 32'h8000_0000));
    send_word(make_word(REQ_QUERY, 2, TOP_POS - 1, 32'h0));
    send_word(make_word(REQ_QUERY, 0, 5, 32'h0));
    send_word(make_word(REQ_QUERY, 5, 1023, 32'h0));
    send_word(make_word(REQ_QUERY, 10, 9, 32'h0));
    send_word(make_word(REQ_QUERY, 0, 0, 32'h0));
    send_word(make_word(REQ_QUERY, 1023, 1023, 32'h0));
    send_word(make_word(REQ_QUERY, 1023, 0, 32'h7FFF_FFFF));
    send_word(make_word(REQ_ADD, 1, 0, 32'h7FFF_FFFF));
    send_word(make_word(REQ_QUERY, 1, 2, 32'h0));
    hold_until_drained();

    // Random: mostly valid adds and ranges, some invalid words and noise
    while (live_items < RUN_ITEMS) begin
      pick = $urandom_range(0, 99);
      hi = $urandom_range(0, 1023);
      d = $urandom();
      if (pick < 45) begin
        op = REQ_ADD;
        lo = (pick < 3) ? (($urandom_range(0, 1) == 0) ? 0 : 1023) : $urandom_range(1, TOP_POS);
        if (pick >= 30)
          d = $urandom_range(0, 2000) - 1000;
      end else if (pick < 90) begin
        op = REQ_QUERY;
        lo = (pick < 50) ? 1 : $urandom_range(1, TOP_POS);
        if (pick < 70)
          hi = (lo + $urandom_range(0, 3) > TOP_POS) ? TOP_POS : lo + $urandom_range(0, 3);
        else if (pick < 75)
          hi = TOP_POS;
        else
          hi = $urandom_range(lo, TOP_POS);
      end else begin
        op = 1'($urandom_range(0, 1));
        lo = $urandom_range(0, 1023);
      end
      send_word(make_word(op, lo, hi, d));
      if (op == REQ_QUERY || (lo != 0 && lo != 1023))
        live_items++;
      if (!mid_pause_done && live_items >= RUN_ITEMS / 2) begin
        hold_until_drained();
        mid_pause_done = 1'b1;
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d queries (%0d with invalid ranges), %0d adds applied and %0d dropped.",
             queries_seen, bad_queries, adds_applied, adds_dropped);
    if (mismatches == 0)
      $display("PASS segment_tree_range_sum_top");
    else
      $display("FAIL segment_tree_range_sum_top");
    $finish;
  end

endmodule

### segment_tree_range_sum_top.f
hdl/strs_pkg.sv
hdl/strs_ram.sv
hdl/strs_dp.sv
hdl/strs_ctrl.sv
hdl/segment_tree_range_sum_top.sv
test/strs_tb_pkg.sv
test/range_sum_checker.sv
test/segment_tree_range_sum_top_tb.sv
